/* src/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg
// shared types and constants of the heightmap brush sculpt pipeline
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int CFG_WIDTH  = 26;
    localparam int ADDR_WIDTH = 3;

    localparam logic [ADDR_WIDTH-1:0] REG_MODE     = 3'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_CENTER_X = 3'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_CENTER_Y = 3'd2;
    localparam logic [ADDR_WIDTH-1:0] REG_INV_RX   = 3'd3;
    localparam logic [ADDR_WIDTH-1:0] REG_INV_RY   = 3'd4;
    localparam logic [ADDR_WIDTH-1:0] REG_FALLOFF  = 3'd5;
    localparam logic [ADDR_WIDTH-1:0] REG_DELTA    = 3'd6;
    localparam logic [ADDR_WIDTH-1:0] REG_LEVEL    = 3'd7;

    localparam logic [1:0] MODE_RAISE   = 2'd0;
    localparam logic [1:0] MODE_LOWER   = 2'd1;
    localparam logic [1:0] MODE_FLATTEN = 2'd2;

    localparam int DIST_MAX   = 262143;
    localparam int SQ_STAGES  = 16;
    localparam int DIV_STAGES = 16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [20:0]        cx;
        logic [20:0]        cy;
        logic [23:0]        irx;
        logic [23:0]        iry;
        logic [16:0]        falloff;
        logic signed [25:0] delta;
        logic [15:0]        level;
    } t_cfg;

endpackage

/* src/hbs_dist.sv */
// ----------------------------------------------------------------------------
// hbs_dist
// elliptical distance: axis offsets, reciprocal scaling, squares and a
// pipelined digit-by-digit square root
// ----------------------------------------------------------------------------
module hbs_dist import hbs_pkg::*; #(
    parameter int COORD_WIDTH = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_grid_x,
    input  logic [COORD_WIDTH-1:0] i_grid_y,
    input  logic [15:0]            i_old,
    output logic                   o_valid,
    output logic [15:0]            o_old,
    output logic                   o_big,
    output logic [15:0]            o_dist
);

    localparam int GW = COORD_WIDTH + 8;
    localparam int MW = (GW > 21) ? GW : 21;
    localparam int PW = MW + 24;
    localparam int SW = 34;

    logic [MW-1:0] gx, gy, cx, cy;
    logic [PW-1:0] qx, qy;
    logic [36:0]   sum;

    logic          r_v1, r_v2, r_v3, r_v4;
    logic [15:0]   r_o1, r_o2, r_o3, r_o4;
    logic [MW-1:0] r_mx, r_my;
    logic [PW-1:0] r_px, r_py;
    logic [17:0]   r_dx, r_dy;
    logic [35:0]   r_sqx, r_sqy;

    logic          r_sval [0:SQ_STAGES];
    logic [SW-1:0] r_sv   [0:SQ_STAGES];
    logic [SW-1:0] r_sr   [0:SQ_STAGES];
    logic [15:0]   r_so   [0:SQ_STAGES];
    logic          r_sb   [0:SQ_STAGES];

    assign gx  = MW'({i_grid_x, 8'h00});
    assign gy  = MW'({i_grid_y, 8'h00});
    assign cx  = MW'(i_cfg.cx);
    assign cy  = MW'(i_cfg.cy);
    assign qx  = (r_px + PW'(128)) >> 8;
    assign qy  = (r_py + PW'(128)) >> 8;
    assign sum = 37'(r_sqx) + 37'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_sval[0] <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_sval[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx  <= (gx >= cx) ? gx - cx : cx - gx;
            r_my  <= (gy >= cy) ? gy - cy : cy - gy;
            r_o1  <= i_old;
            r_px  <= PW'(r_mx) * PW'(i_cfg.irx);
            r_py  <= PW'(r_my) * PW'(i_cfg.iry);
            r_o2  <= r_o1;
            r_dx  <= (qx > PW'(DIST_MAX)) ? 18'(DIST_MAX) : qx[17:0];
            r_dy  <= (qy > PW'(DIST_MAX)) ? 18'(DIST_MAX) : qy[17:0];
            r_o3  <= r_o2;
            r_sqx <= 36'(r_dx) * 36'(r_dx);
            r_sqy <= 36'(r_dy) * 36'(r_dy);
            r_o4  <= r_o3;
            r_sv[0] <= SW'(sum[31:0]);
            r_sr[0] <= '0;
            r_so[0] <= r_o4;
            r_sb[0] <= (sum[36:32] != 5'd0);
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        localparam logic [SW-1:0] BIT = SW'(1) << (30 - 2 * k);
        logic [SW-1:0] trial;
        assign trial = r_sr[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sval[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sval[k+1] <= r_sval[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sv[k] >= trial) begin
                    r_sv[k+1] <= r_sv[k] - trial;
                    r_sr[k+1] <= (r_sr[k] >> 1) + BIT;
                end else begin
                    r_sv[k+1] <= r_sv[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
                r_so[k+1] <= r_so[k];
                r_sb[k+1] <= r_sb[k];
            end
        end
    end

    assign o_valid = r_sval[SQ_STAGES];
    assign o_old   = r_so[SQ_STAGES];
    assign o_big   = r_sb[SQ_STAGES];
    assign o_dist  = r_sr[SQ_STAGES][15:0];

endmodule

/* src/hbs_wgt.sv */
// ----------------------------------------------------------------------------
// hbs_wgt
// brush weight: core test, pipelined restoring divide across the falloff
// band and the smoothstep polynomial
// ----------------------------------------------------------------------------
module hbs_wgt import hbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [15:0] i_old,
    input  logic        i_big,
    input  logic [15:0] i_dist,
    output logic        o_valid,
    output logic [15:0] o_old,
    output logic [16:0] o_w
);

    typedef struct packed {
        logic [15:0] old;
        logic        zero;
        logic        full;
    } t_wflag;

    logic [16:0] fo, inner, d17, num;
    logic [17:0] fo18;
    logic [49:0] rnd;
    logic [17:0] s;

    logic        r_dval [0:DIV_STAGES];
    logic [17:0] r_rem  [0:DIV_STAGES];
    logic [15:0] r_q    [0:DIV_STAGES];
    t_wflag      r_fl   [0:DIV_STAGES];

    logic        r_v1, r_v2, r_v3;
    t_wflag      r_f1, r_f2;
    logic [31:0] r_tt;
    logic [17:0] r_m;
    logic [49:0] r_prod;
    logic [15:0] r_old;
    logic [16:0] r_w;

    assign fo    = (i_cfg.falloff > 17'd65536) ? 17'd65536 : i_cfg.falloff;
    assign fo18  = {1'b0, fo};
    assign inner = 17'd65536 - fo;
    assign d17   = {1'b0, i_dist};
    assign num   = d17 - inner;
    assign rnd   = r_prod + 50'h0_8000_0000;
    assign s     = rnd[49:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dval[0] <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_dval[0] <= i_valid;
            r_v1 <= r_dval[DIV_STAGES];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= {2'b00, num[15:0]};
            r_q[0]       <= '0;
            r_fl[0].old  <= i_old;
            r_fl[0].zero <= i_big;
            r_fl[0].full <= (d17 <= inner);
            r_tt   <= 32'(r_q[DIV_STAGES]) * 32'(r_q[DIV_STAGES]);
            r_m    <= 18'd196608 - {1'b0, r_q[DIV_STAGES], 1'b0};
            r_f1   <= r_fl[DIV_STAGES];
            r_prod <= 50'(r_tt) * 50'(r_m);
            r_f2   <= r_f1;
            r_old  <= r_f2.old;
            if (r_f2.zero) begin
                r_w <= '0;
            end else if (r_f2.full) begin
                r_w <= 17'd65536;
            end else if (s >= 18'd65536) begin
                r_w <= '0;
            end else begin
                r_w <= 17'(18'd65536 - s);
            end
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [17:0] rem2;
        assign rem2 = {r_rem[k][16:0], 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dval[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dval[k+1] <= r_dval[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= fo18) begin
                    r_rem[k+1] <= rem2 - fo18;
                    r_q[k+1]   <= {r_q[k][14:0], 1'b1};
                end else begin
                    r_rem[k+1] <= rem2;
                    r_q[k+1]   <= {r_q[k][14:0], 1'b0};
                end
                r_fl[k+1] <= r_fl[k];
            end
        end
    end

    assign o_valid = r_v3;
    assign o_old   = r_old;
    assign o_w     = r_w;

endmodule

/* src/hbs_apply.sv */
// ----------------------------------------------------------------------------
// hbs_apply
// applies the weighted move to the height, rounds and clamps, and holds
// results in an output register with a skid stage
// ----------------------------------------------------------------------------
module hbs_apply import hbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [15:0] i_old,
    input  logic [16:0] i_w,
    output logic        o_en,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_height,
    output logic        o_touched
);

    logic               en;
    logic signed [16:0] fdiff;
    logic signed [45:0] h_up, h_dn;
    logic signed [36:0] h_fl;
    logic [15:0]        n_height;
    logic               out_free;

    logic               r_v1, r_v2;
    logic signed [43:0] r_move;
    logic signed [34:0] r_fm;
    logic [15:0]        r_old1;
    logic [16:0]        r_w1;
    logic [15:0]        r_h2;
    logic               r_t2;
    logic               r_out_valid, r_skid_valid;
    logic [15:0]        r_out_h, r_skid_h;
    logic               r_out_t, r_skid_t;

    function automatic logic [15:0] clamp46(input logic signed [45:0] h);
        logic [15:0] r;
        if (h[45]) begin
            r = '0;
        end else if (h[44:40] != 5'd0) begin
            r = 16'hFFFF;
        end else begin
            r = h[39:24];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp37(input logic signed [36:0] h);
        logic [15:0] r;
        if (h[36]) begin
            r = '0;
        end else if (h[35:32] != 4'd0) begin
            r = 16'hFFFF;
        end else begin
            r = h[31:16];
        end
        return r;
    endfunction

    assign en       = !r_skid_valid;
    assign o_en     = en;
    assign out_free = !r_out_valid || i_ready;
    assign fdiff    = $signed({1'b0, i_cfg.level}) - $signed({1'b0, i_old});
    assign h_up     = $signed({6'b0, r_old1, 24'b0}) + 46'(r_move) + 46'sh800000;
    assign h_dn     = $signed({6'b0, r_old1, 24'b0}) - 46'(r_move) + 46'sh800000;
    assign h_fl     = $signed({5'b0, r_old1, 16'b0}) + 37'(r_fm) + 37'sh8000;

    always_comb begin
        n_height = r_old1;
        if (r_w1 != 17'd0) begin
            case (i_cfg.mode)
                MODE_RAISE:   n_height = clamp46(h_up);
                MODE_LOWER:   n_height = clamp46(h_dn);
                MODE_FLATTEN: n_height = clamp37(h_fl);
                default:      n_height = r_old1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_move <= 44'(i_cfg.delta) * 44'($signed({1'b0, i_w}));
            r_fm   <= 35'(fdiff) * 35'($signed({1'b0, i_w}));
            r_old1 <= i_old;
            r_w1   <= i_w;
            r_h2   <= n_height;
            r_t2   <= (r_w1 != 17'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_v2;
            end
        end else if (r_v2 && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_h <= r_skid_h;
                r_out_t <= r_skid_t;
            end else begin
                r_out_h <= r_h2;
                r_out_t <= r_t2;
            end
        end else if (r_v2 && en) begin
            r_skid_h <= r_h2;
            r_skid_t <= r_t2;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_height  = r_out_h;
    assign o_touched = r_out_t;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready && r_v2))
        else $error("skid filled without a stalled output");

    a_stall_keeps_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

/* src/heightmap_brush_sculpt.sv */
// ----------------------------------------------------------------------------
// heightmap_brush_sculpt
// smoothstep fall-off elliptical brush applied to a stream of heightmap vertices
// ----------------------------------------------------------------------------
// One vertex item is taken per clock and one sculpted height comes out per item,
// in order, through 21 stages for the offsets, squares and the
// 16-step square root, 20 for the core test, the 16-step divide across the
// fall-off band and the smoothstep, 2 to apply the move and clamp, and the
// output register. A result stalled at the output is held there and one more
// item in a skid stage; the input pauses only while that skid stage is full.
// Registers are written through the plain write port and should only be changed
// while no item is in flight.
module heightmap_brush_sculpt import hbs_pkg::*; #(
    parameter int COORD_WIDTH = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [CFG_WIDTH-1:0]  i_cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // grid_x, grid_y, old_height, zero fill
    input  logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_height
    output logic [15:0]           m_tdata,
    // touched
    output logic                  m_tuser
);

    t_cfg        r_cfg;
    logic        en;
    logic        d_valid, d_big;
    logic [15:0] d_old, d_dist;
    logic        w_valid;
    logic [15:0] w_old;
    logic [16:0] w_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_RAISE;
            r_cfg.cx      <= '0;
            r_cfg.cy      <= '0;
            r_cfg.irx     <= 24'd65536;
            r_cfg.iry     <= 24'd65536;
            r_cfg.falloff <= 17'd32768;
            r_cfg.delta   <= '0;
            r_cfg.level   <= 16'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:     r_cfg.mode    <= i_cfg_wdata[1:0];
                REG_CENTER_X: r_cfg.cx      <= i_cfg_wdata[20:0];
                REG_CENTER_Y: r_cfg.cy      <= i_cfg_wdata[20:0];
                REG_INV_RX:   r_cfg.irx     <= i_cfg_wdata[23:0];
                REG_INV_RY:   r_cfg.iry     <= i_cfg_wdata[23:0];
                REG_FALLOFF:  r_cfg.falloff <= i_cfg_wdata[16:0];
                REG_DELTA:    r_cfg.delta   <= $signed(i_cfg_wdata[25:0]);
                REG_LEVEL:    r_cfg.level   <= i_cfg_wdata[15:0];
                default:      r_cfg         <= r_cfg;
            endcase
        end
    end

    assign s_tready = en;

    hbs_dist #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_valid  (s_tvalid && en),
        .i_grid_x (s_tdata[COORD_WIDTH-1:0]),
        .i_grid_y (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_old    (s_tdata[2*COORD_WIDTH+15:2*COORD_WIDTH]),
        .o_valid  (d_valid),
        .o_old    (d_old),
        .o_big    (d_big),
        .o_dist   (d_dist)
    );

    hbs_wgt u_wgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (d_valid),
        .i_old   (d_old),
        .i_big   (d_big),
        .i_dist  (d_dist),
        .o_valid (w_valid),
        .o_old   (w_old),
        .o_w     (w_w)
    );

    hbs_apply u_apply (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_valid),
        .i_old     (w_old),
        .i_w       (w_w),
        .o_en      (en),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_height  (m_tdata),
        .o_touched (m_tuser)
    );

endmodule
